// ----- src/trs_pkg.sv -----
// shared constants, types and latency helpers for the model matrix builder
package trs_pkg;

  localparam int DEF_DATA_WIDTH      = 32;
  localparam int DEF_FRAC_BITS       = 16;
  localparam int DEF_TRIG_ITERATIONS = 16;

  // cordic datapath width (q30 plus headroom) and width of a finished cos/sin
  localparam int ANGLE_W = 34;
  localparam int TRIG_W  = 32;

  localparam longint DEG_TO_RAD_Q30  = 18740330;
  localparam longint CORDIC_GAIN_Q30 = 652032874;

  localparam int ATAN_ENTRIES = 24;
  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic signed [TRIG_W-1:0] cs;
    logic signed [TRIG_W-1:0] sn;
  } trig_t;

  // exponent of the highest power-of-two multiple of a full turn used by the angle reduction
  function automatic int red_steps(input int dw, input int fb);
    return (dw - 9 - fb > 0) ? dw - 9 - fb : 0;
  endfunction

  function automatic int lane_latency(input int dw, input int fb, input int ti);
    return red_steps(dw, fb) + ti + 5;
  endfunction

  // q30 by q30 product, rounded back to q30
  function automatic logic signed [ANGLE_W-1:0] mulq(input logic signed [ANGLE_W-1:0] a,
                                                      input logic signed [ANGLE_W-1:0] b);
    logic signed [2*ANGLE_W-1:0] p;
    p = a * b;
    p = (p + ((2*ANGLE_W)'(1) <<< 29)) >>> 30;
    return p[ANGLE_W-1:0];
  endfunction

endpackage

// ----- src/trs_trig_lane.sv -----
// one angle lane: modulo 360 reduction, quadrant fold, radians and pipelined cordic
module trs_trig_lane #(
  parameter int DATA_WIDTH      = trs_pkg::DEF_DATA_WIDTH,
  parameter int FRAC_BITS       = trs_pkg::DEF_FRAC_BITS,
  parameter int TRIG_ITERATIONS = trs_pkg::DEF_TRIG_ITERATIONS
) (
  input  logic                         clk,
  input  logic signed [DATA_WIDTH-1:0] angle,
  output trs_pkg::trig_t               trig
);
  import trs_pkg::*;

  localparam int S   = red_steps(DATA_WIDTH, FRAC_BITS);
  localparam int RW  = ((DATA_WIDTH > FRAC_BITS + 10) ? DATA_WIDTH : FRAC_BITS + 10) + 2;
  localparam int RDW = FRAC_BITS + 9;
  localparam int PW  = RDW + 27;
  localparam int ZW  = ANGLE_W;

  localparam logic signed [RW-1:0] FULL    = RW'(longint'(360) <<< FRAC_BITS);
  localparam logic signed [RW-1:0] HALF    = RW'(longint'(180) <<< FRAC_BITS);
  localparam logic signed [RW-1:0] QUARTER = RW'(longint'(90) <<< FRAC_BITS);
  localparam logic signed [RW-1:0] OFFSET  = FULL <<< S;
  localparam logic signed [26:0]   DEG     = 27'(DEG_TO_RAD_Q30);
  localparam logic signed [PW-1:0] RND     = PW'(1) <<< (FRAC_BITS - 1);

  logic signed [RW-1:0]  red [S+2];
  logic signed [RW-1:0]  r_wrap;
  logic signed [RW-1:0]  fold;
  logic                  flip_c;
  logic signed [RDW-1:0] fold_r;
  logic                  flip_r;
  logic signed [PW-1:0]  prod_c;
  logic signed [PW-1:0]  zr_c;
  logic signed [ZW-1:0]  cx [TRIG_ITERATIONS+1];
  logic signed [ZW-1:0]  cy [TRIG_ITERATIONS+1];
  logic signed [ZW-1:0]  cz [TRIG_ITERATIONS+1];
  logic                  cf [TRIG_ITERATIONS+1];

  // offset by a multiple of a full turn so the residue search sees a positive value
  always_ff @(posedge clk) begin
    red[0] <= RW'(angle) + OFFSET;
  end

  for (genvar j = 0; j <= S; j++) begin : g_red
    localparam logic signed [RW-1:0] STEP = FULL <<< (S - j);
    always_ff @(posedge clk) begin
      red[j+1] <= (red[j] >= STEP) ? red[j] - STEP : red[j];
    end
  end

  always_comb begin
    r_wrap = red[S+1];
    if (r_wrap > HALF) begin
      r_wrap = r_wrap - FULL;
    end
    fold   = r_wrap;
    flip_c = 1'b0;
    if (r_wrap > QUARTER) begin
      fold   = r_wrap - HALF;
      flip_c = 1'b1;
    end else if (r_wrap < -QUARTER) begin
      fold   = r_wrap + HALF;
      flip_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    fold_r <= fold[RDW-1:0];
    flip_r <= flip_c;
  end

  assign prod_c = fold_r * DEG;
  assign zr_c   = (prod_c + RND) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    cx[0] <= ZW'(CORDIC_GAIN_Q30);
    cy[0] <= '0;
    cz[0] <= zr_c[ZW-1:0];
    cf[0] <= flip_r;
  end

  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] AT = ZW'(ATAN_Q30[i]);
    always_ff @(posedge clk) begin
      if (!cz[i][ZW-1]) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - AT;
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + AT;
      end
      cf[i+1] <= cf[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cf[TRIG_ITERATIONS]) begin
      trig.cs <= TRIG_W'(-cx[TRIG_ITERATIONS]);
      trig.sn <= TRIG_W'(-cy[TRIG_ITERATIONS]);
    end else begin
      trig.cs <= TRIG_W'(cx[TRIG_ITERATIONS]);
      trig.sn <= TRIG_W'(cy[TRIG_ITERATIONS]);
    end
  end

endmodule

// ----- src/trs_matrix_merge.sv -----
// merges the three lanes into rz*ry*rx, scales the columns and saturates
module trs_matrix_merge #(
  parameter int DATA_WIDTH = trs_pkg::DEF_DATA_WIDTH
) (
  input  logic                         clk,
  input  trs_pkg::trig_t               trig_x,
  input  trs_pkg::trig_t               trig_y,
  input  trs_pkg::trig_t               trig_z,
  input  logic signed [DATA_WIDTH-1:0] scale [3],
  output logic signed [DATA_WIDTH-1:0] m [9]
);
  import trs_pkg::*;

  localparam int MIX = ((62 - DATA_WIDTH) < 30) ? (62 - DATA_WIDTH) : 30;
  localparam int SH  = 30 - MIX;
  localparam int RMW = ANGLE_W - SH;
  localparam int PRW = RMW + DATA_WIDTH;
  localparam logic signed [PRW-1:0] MAXV = PRW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam logic signed [PRW-1:0] MINV = -MAXV - PRW'(1);
  localparam logic signed [PRW-1:0] RND  = PRW'(1) <<< (MIX - 1);

  logic signed [ANGLE_W-1:0] cx, sx, cy, sy, cz, sz;
  logic signed [ANGLE_W-1:0] czcy, szcy, czsy, szsy, szcx, szsx, czcx, czsx, cysx, cycx;
  logic signed [ANGLE_W-1:0] sx_a, cx_a, nsy_a;
  logic signed [DATA_WIDTH-1:0] scl_a [3];
  logic signed [DATA_WIDTH-1:0] scl_b [3];
  logic signed [ANGLE_W-1:0] rot [9];
  logic signed [RMW-1:0]     rm [9];
  logic signed [PRW-1:0]     prod [9];
  logic signed [PRW-1:0]     mr [9];

  assign cx = ANGLE_W'(trig_x.cs);
  assign sx = ANGLE_W'(trig_x.sn);
  assign cy = ANGLE_W'(trig_y.cs);
  assign sy = ANGLE_W'(trig_y.sn);
  assign cz = ANGLE_W'(trig_z.cs);
  assign sz = ANGLE_W'(trig_z.sn);

  // pair products
  always_ff @(posedge clk) begin
    czcy  <= mulq(cz, cy);
    szcy  <= mulq(sz, cy);
    czsy  <= mulq(cz, sy);
    szsy  <= mulq(sz, sy);
    szcx  <= mulq(sz, cx);
    szsx  <= mulq(sz, sx);
    czcx  <= mulq(cz, cx);
    czsx  <= mulq(cz, sx);
    cysx  <= mulq(cy, sx);
    cycx  <= mulq(cy, cx);
    sx_a  <= sx;
    cx_a  <= cx;
    nsy_a <= -sy;
    scl_a <= scale;
  end

  // triple products and sums
  always_ff @(posedge clk) begin
    rot[0] <= czcy;
    rot[1] <= mulq(czsy, sx_a) - szcx;
    rot[2] <= mulq(czsy, cx_a) + szsx;
    rot[3] <= szcy;
    rot[4] <= mulq(szsy, sx_a) + czcx;
    rot[5] <= mulq(szsy, cx_a) - czsx;
    rot[6] <= nsy_a;
    rot[7] <= cysx;
    rot[8] <= cycx;
    scl_b  <= scl_a;
  end

  for (genvar k = 0; k < 9; k++) begin : g_col
    logic signed [ANGLE_W-1:0] rr;
    if (SH > 0) begin : g_rnd
      assign rr = (rot[k] + (ANGLE_W'(1) <<< (SH - 1))) >>> SH;
    end else begin : g_keep
      assign rr = rot[k];
    end
    assign rm[k] = rr[RMW-1:0];

    always_ff @(posedge clk) begin
      prod[k] <= rm[k] * scl_b[k % 3];
    end

    assign mr[k] = (prod[k] + RND) >>> MIX;

    always_ff @(posedge clk) begin
      if (mr[k] > MAXV) begin
        m[k] <= MAXV[DATA_WIDTH-1:0];
      end else if (mr[k] < MINV) begin
        m[k] <= MINV[DATA_WIDTH-1:0];
      end else begin
        m[k] <= mr[k][DATA_WIDTH-1:0];
      end
    end
  end

endmodule

// ----- src/trs_model_matrix_builder_unit.sv -----
// top level of the model matrix builder: lanes, merge stage and request pipeline
//
// Builds the model matrix T*R*S for one object per request. A request is taken
// on every clock edge with start high; busy is tied low, so a new request may
// follow in every cycle. Each result appears for exactly one cycle with done
// high, once the request has passed the angle residue search, the quadrant fold
// and the cordic stages in each lane and then the matrix merge stages. The
// receiver cannot stall the block, so results must be taken when offered.
// Throughput is one matrix per clock.
module trs_model_matrix_builder_unit #(
  parameter int DATA_WIDTH      = trs_pkg::DEF_DATA_WIDTH,
  parameter int FRAC_BITS       = trs_pkg::DEF_FRAC_BITS,
  parameter int TRIG_ITERATIONS = trs_pkg::DEF_TRIG_ITERATIONS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] pos_x,
  input  logic signed [DATA_WIDTH-1:0] pos_y,
  input  logic signed [DATA_WIDTH-1:0] pos_z,
  input  logic signed [DATA_WIDTH-1:0] angle_x_deg,
  input  logic signed [DATA_WIDTH-1:0] angle_y_deg,
  input  logic signed [DATA_WIDTH-1:0] angle_z_deg,
  input  logic signed [DATA_WIDTH-1:0] scale_x,
  input  logic signed [DATA_WIDTH-1:0] scale_y,
  input  logic signed [DATA_WIDTH-1:0] scale_z,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] m00,
  output logic signed [DATA_WIDTH-1:0] m01,
  output logic signed [DATA_WIDTH-1:0] m02,
  output logic signed [DATA_WIDTH-1:0] m10,
  output logic signed [DATA_WIDTH-1:0] m11,
  output logic signed [DATA_WIDTH-1:0] m12,
  output logic signed [DATA_WIDTH-1:0] m20,
  output logic signed [DATA_WIDTH-1:0] m21,
  output logic signed [DATA_WIDTH-1:0] m22,
  output logic signed [DATA_WIDTH-1:0] tx,
  output logic signed [DATA_WIDTH-1:0] ty,
  output logic signed [DATA_WIDTH-1:0] tz
);
  import trs_pkg::*;

  // lane latency, then four merge stages
  localparam int LL  = lane_latency(DATA_WIDTH, FRAC_BITS, TRIG_ITERATIONS);
  localparam int TOT = LL + 4;

  trig_t trig_x, trig_y, trig_z;

  logic                         vld [TOT];
  logic signed [DATA_WIDTH-1:0] scl_dl [LL][3];
  logic signed [DATA_WIDTH-1:0] pos_dl [TOT][3];
  logic signed [DATA_WIDTH-1:0] m [9];

  // never stalls
  assign busy = 1'b0;

  // request valid line, the only state that needs reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TOT; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      vld[0] <= start;
      for (int i = 1; i < TOT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // scale meets the lane outputs at the merge input, position meets the result
  always_ff @(posedge clk) begin
    scl_dl[0] <= '{scale_x, scale_y, scale_z};
    for (int i = 1; i < LL; i++) begin
      scl_dl[i] <= scl_dl[i-1];
    end
    pos_dl[0] <= '{pos_x, pos_y, pos_z};
    for (int i = 1; i < TOT; i++) begin
      pos_dl[i] <= pos_dl[i-1];
    end
  end

  // one trig lane per euler angle
  trs_trig_lane #(
    .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_lane_x (.clk(clk), .angle(angle_x_deg), .trig(trig_x));

  trs_trig_lane #(
    .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_lane_y (.clk(clk), .angle(angle_y_deg), .trig(trig_y));

  trs_trig_lane #(
    .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_lane_z (.clk(clk), .angle(angle_z_deg), .trig(trig_z));

  // rotation products, column scaling and saturation
  trs_matrix_merge #(.DATA_WIDTH(DATA_WIDTH)) u_merge (
    .clk   (clk),
    .trig_x(trig_x),
    .trig_y(trig_y),
    .trig_z(trig_z),
    .scale (scl_dl[LL-1]),
    .m     (m)
  );

  assign done = vld[TOT-1];
  assign m00  = m[0];
  assign m01  = m[1];
  assign m02  = m[2];
  assign m10  = m[3];
  assign m11  = m[4];
  assign m12  = m[5];
  assign m20  = m[6];
  assign m21  = m[7];
  assign m22  = m[8];
  assign tx   = pos_dl[TOT-1][0];
  assign ty   = pos_dl[TOT-1][1];
  assign tz   = pos_dl[TOT-1][2];

endmodule
